// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the sonar frame delimiter
// Byte codes, header geometry, byte status codes and the result bundle
// handed from the frame tracker to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned LEN_W    = 16;

  localparam logic [BYTE_W-1:0] START_BYTE   = 8'h40;
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] SHORT_TYPE   = 8'h08;

  localparam logic [OFFSET_W-1:0] HEADER_EXTRA = 17'd5;
  localparam logic [OFFSET_W-1:0] TYPE_OFFSET  = 17'd10;
  localparam logic [OFFSET_W-1:0] LEN_LO_OFF   = 17'd5;
  localparam logic [OFFSET_W-1:0] LEN_HI_OFF   = 17'd6;
  localparam logic [OFFSET_W-1:0] HEX_FIRST    = 17'd1;
  localparam logic [OFFSET_W-1:0] HEX_LAST     = 17'd4;

  typedef enum logic [2:0] {
    ST_SKIP     = 3'd0,
    ST_INSIDE   = 3'd1,
    ST_GOOD_END = 3'd2,
    ST_REJECT   = 3'd3,
    ST_NO_TERM  = 3'd4
  } status_t;

  typedef enum logic {
    PH_HUNT  = 1'b0,
    PH_FRAME = 1'b1
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [OFFSET_W-1:0] offset;
    status_t             status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sfd_tracker.sv =====
// ----------------------------------------------------------------------------
// sfd_tracker: frame state and per-byte classification
// Holds the hunt/frame phase, the byte position and the header fields, and
// classifies the byte presented on byte_i. State moves only on advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfd_tracker
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] byte_i,
  output res_t                   result
);

  // Returns {valid, nibble}; valid is low for a character that is not hex.
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  phase_t              phase_r, phase_nxt;
  logic [OFFSET_W-1:0] position_r, position_nxt;
  logic [LEN_W-1:0]    ascii_len_r, ascii_len_nxt;
  logic [LEN_W-1:0]    bin_len_r, bin_len_nxt;
  logic [BYTE_W-1:0]   type_r, type_nxt;

  status_t             status;
  logic [OFFSET_W-1:0] off;
  logic [4:0]          hex;
  logic [LEN_W-1:0]    bin_full;
  logic [BYTE_W-1:0]   type_eff;
  logic [OFFSET_W-1:0] end_normal;
  logic [OFFSET_W-1:0] end_short;

  assign off        = (phase_r == PH_FRAME) ? position_r : '0;
  assign hex        = hex_decode(byte_i);
  assign bin_full   = {byte_i, bin_len_r[BYTE_W-1:0]};
  assign type_eff   = (off == TYPE_OFFSET) ? byte_i : type_r;
  assign end_normal = {1'b0, bin_len_r} + HEADER_EXTRA;
  assign end_short  = end_normal - 17'd1;

  // Byte classification and header field updates.
  always_comb begin
    status        = ST_SKIP;
    ascii_len_nxt = ascii_len_r;
    bin_len_nxt   = bin_len_r;
    type_nxt      = type_r;
    if (phase_r == PH_HUNT) begin
      if (byte_i == START_BYTE) begin
        status        = ST_INSIDE;
        ascii_len_nxt = '0;
        bin_len_nxt   = '0;
        type_nxt      = '0;
      end
    end else begin
      status = ST_INSIDE;
      if (off >= HEX_FIRST && off <= HEX_LAST) begin
        if (!hex[4]) begin
          status = ST_REJECT;
        end else begin
          ascii_len_nxt = {ascii_len_r[LEN_W-5:0], hex[3:0]};
        end
      end else if (off == LEN_LO_OFF) begin
        bin_len_nxt = {{(LEN_W-BYTE_W){1'b0}}, byte_i};
      end else if (off == LEN_HI_OFF) begin
        bin_len_nxt = bin_full;
        if (bin_full != ascii_len_r || {1'b0, bin_full} < HEADER_EXTRA) begin
          status = ST_REJECT;
        end
      end else begin
        type_nxt = type_eff;
        if (off >= TYPE_OFFSET && type_eff == SHORT_TYPE && off == end_short) begin
          status = ST_GOOD_END;
        end else if (off >= end_normal) begin
          status = (byte_i == NEWLINE_BYTE) ? ST_GOOD_END : ST_NO_TERM;
        end
      end
    end
  end

  // Phase and position follow from the byte status.
  always_comb begin
    phase_nxt    = PH_HUNT;
    position_nxt = '0;
    if (status == ST_INSIDE) begin
      phase_nxt    = PH_FRAME;
      position_nxt = off + 17'd1;
    end
  end

  assign result = '{data: byte_i, offset: off, status: status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      position_r  <= '0;
      ascii_len_r <= '0;
      bin_len_r   <= '0;
      type_r      <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      position_r  <= position_nxt;
      ascii_len_r <= ascii_len_nxt;
      bin_len_r   <= bin_len_nxt;
      type_r      <= type_nxt;
    end
  end

  a_reject_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (result.status == ST_REJECT || result.status == ST_NO_TERM)
    |=> phase_r == PH_HUNT)
    else $error("rejected byte did not return to hunting");

  a_hunt_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT |-> result.offset == '0)
    else $error("nonzero offset while hunting");

  a_frame_position: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FRAME |-> position_r != '0)
    else $error("frame position zero inside a frame");

  a_hunt_status: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT |-> (result.status == ST_SKIP || result.status == ST_INSIDE))
    else $error("end status while hunting");

endmodule

`default_nettype wire

// ===== rtl/sonar_frame_delimiter.sv =====
// ----------------------------------------------------------------------------
// sonar_frame_delimiter: serial byte stream frame delimiter
// Tags each received byte with its offset inside the current frame and a
// status: skipped while hunting, inside a frame, good frame end, header
// rejected or terminator missing.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Ports                  | Content
//  --------+-----+------------------------+----------------------------------
//  in_     | in  | tvalid/tready/tdata[7:0] | data_byte, one per beat
//  out_    | out | tvalid/tready/tdata[31:0]/tuser[2:0]/tlast | tagged byte
//
// One beat in and one beat out per cycle while out_tready stays high; a byte
// passes through the input register, then the result register.
// The classification of a byte is one pass of logic between the input
// register and the result register, and the frame state updates as the byte
// moves into the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// tracker to hunting for the start byte with all header fields cleared.
// A stall on out_tready holds the result register; the input register still
// drains into it when it empties, and in_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module sonar_frame_delimiter
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] out_byte, [24:8] frame_offset, rest zero
  output logic [2:0]       out_tuser,  // [2:0] byte_status
  output logic             out_tlast   // frame_end
);

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  logic              advance;
  res_t              result;

  // A byte moves from the input register into the result register whenever
  // the result register is empty or being read in this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign s1_valid_nxt  = (in_tvalid && in_tready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  sfd_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_i  (s1_byte_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.offset, out_res_r.data};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = (out_res_r.status == ST_GOOD_END);

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("result register changed while stalled");

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready while input register empty");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced byte lost");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sonar frame delimiter
// Feeds a byte stream of hand-written and randomly built frames, good and
// broken, through the input stream and checks every tagged result beat
// against a byte-by-byte frame tracker kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DIR_ROWS     = 28;

  localparam bit FREE  = 1'b0;
  localparam bit FIXED = 1'b1;

  // What one result beat should carry.
  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [OFFSET_W-1:0] offset;
    status_t             status;
    logic                last;
  } tag_t;

  // One byte to send; a FIXED row also carries its expected offset and status.
  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    bit                  fixed;
    logic [OFFSET_W-1:0] offset;
    status_t             status;
  } plan_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [7:0] out_byte, [24:8] frame_offset
  logic [2:0]  out_tuser;           // [2:0] byte_status
  logic        out_tlast;           // frame_end

  sonar_frame_delimiter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Directed bytes. Offsets and status are typed in where they are obvious;
  // the remaining rows are left to the tracker.
  plan_row_t directed_rows [DIR_ROWS] = '{
    // Idle line right after reset.
    '{8'h00, FIXED, 17'd0, ST_SKIP},
    // Start byte, then a second start byte in the first length digit: it is
    // rejected and not taken as a new start.
    '{8'h40, FIXED, 17'd0, ST_INSIDE},
    '{8'h40, FIXED, 17'd1, ST_REJECT},
    // Length 4 in both forms: too short, rejected at the high length byte.
    '{8'h40, FIXED, 17'd0, ST_INSIDE},
    '{8'h30, FREE,  17'd0, ST_INSIDE},
    '{8'h30, FREE,  17'd0, ST_INSIDE},
    '{8'h30, FREE,  17'd0, ST_INSIDE},
    '{8'h34, FREE,  17'd0, ST_INSIDE},
    '{8'h04, FREE,  17'd0, ST_INSIDE},
    '{8'h00, FIXED, 17'd6, ST_REJECT},
    // Length 5 with the short type byte: the type byte sits where the
    // newline belongs, so the frame fails on its terminator.
    '{8'h40, FIXED, 17'd0, ST_INSIDE},
    '{8'h30, FREE,  17'd0, ST_INSIDE},
    '{8'h30, FREE,  17'd0, ST_INSIDE},
    '{8'h30, FREE,  17'd0, ST_INSIDE},
    '{8'h35, FREE,  17'd0, ST_INSIDE},
    '{8'h05, FREE,  17'd0, ST_INSIDE},
    '{8'h00, FREE,  17'd0, ST_INSIDE},
    '{8'hA5, FREE,  17'd0, ST_INSIDE},
    '{8'h5A, FREE,  17'd0, ST_INSIDE},
    '{8'h0A, FREE,  17'd0, ST_INSIDE},
    '{8'h08, FIXED, 17'd10, ST_NO_TERM},
    // Mixed-case hex FFFF against binary FFFE: length mismatch.
    '{8'h40, FIXED, 17'd0, ST_INSIDE},
    '{8'h46, FREE,  17'd0, ST_INSIDE},
    '{8'h66, FREE,  17'd0, ST_INSIDE},
    '{8'h46, FREE,  17'd0, ST_INSIDE},
    '{8'h46, FREE,  17'd0, ST_INSIDE},
    '{8'hFE, FREE,  17'd0, ST_INSIDE},
    '{8'hFF, FIXED, 17'd6, ST_REJECT}
  };

  plan_row_t byte_plan [$];
  int        phase_start [3];
  tag_t      pending_tags [$];

  int     accept_idx = 0;
  int     fail_cnt   = 0;
  int     cycle_cnt  = 0;
  int     cur_phase  = 0;
  int     send_idle  = 14;
  int     recv_idle  = 80;
  logic   hold_ready = 1'b0;

  // Tracker state, a copy of what the block keeps.
  phase_t              trk_phase  = PH_HUNT;
  logic [OFFSET_W-1:0] trk_pos    = '0;
  logic [LEN_W-1:0]    hex_len    = '0;
  logic [LEN_W-1:0]    bin_len    = '0;
  logic [BYTE_W-1:0]   frame_type = '0;

  function automatic int hex_digit(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    return -1;
  endfunction

  // Advances the tracker by one byte and returns the tag it should get.
  function automatic tag_t tag_byte(logic [7:0] b);
    tag_t                r;
    int                  hv;
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] blen;
    r.data   = b;
    r.offset = '0;
    r.status = ST_SKIP;
    if (trk_phase == PH_HUNT) begin
      if (b == START_BYTE) begin
        hex_len    = '0;
        bin_len    = '0;
        frame_type = '0;
        trk_phase  = PH_FRAME;
        trk_pos    = 17'd1;
        r.status   = ST_INSIDE;
      end
    end else begin
      off      = trk_pos;
      r.offset = off;
      r.status = ST_INSIDE;
      if (off >= HEX_FIRST && off <= HEX_LAST) begin
        hv = hex_digit(b);
        if (hv < 0) begin
          r.status = ST_REJECT;
        end else begin
          hex_len = {hex_len[11:0], hv[3:0]};
        end
      end else if (off == LEN_LO_OFF) begin
        bin_len = {8'h00, b};
      end else if (off == LEN_HI_OFF) begin
        bin_len[15:8] = b;
        if (bin_len != hex_len || {1'b0, bin_len} < HEADER_EXTRA) r.status = ST_REJECT;
      end else begin
        if (off == TYPE_OFFSET) frame_type = b;
        blen = {1'b0, bin_len} + HEADER_EXTRA;
        if (off >= TYPE_OFFSET && frame_type == SHORT_TYPE && off == blen - 17'd1) begin
          r.status = ST_GOOD_END;
        end else if (off >= blen) begin
          r.status = (b == NEWLINE_BYTE) ? ST_GOOD_END : ST_NO_TERM;
        end
      end
      if (r.status == ST_INSIDE) begin
        trk_pos = off + 17'd1;
      end else begin
        trk_phase = PH_HUNT;
        trk_pos   = '0;
      end
    end
    r.last = (r.status == ST_GOOD_END);
    return r;
  endfunction

  function automatic void plan_byte(logic [7:0] b);
    plan_row_t row;
    row.data   = b;
    row.fixed  = FREE;
    row.offset = '0;
    row.status = ST_INSIDE;
    byte_plan = {byte_plan, row};
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return 8'h30 + {4'h0, d};
    return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, d} - 8'd10;
  endfunction

  function automatic logic [7:0] byte_except(logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == x);
    return b;
  endfunction

  function automatic void plan_noise(int n);
    for (int i = 0; i < n; i++) plan_byte(8'($urandom_range(255)));
  endfunction

  function automatic void plan_header(logic [15:0] text_len, logic [15:0] bin);
    plan_byte(START_BYTE);
    for (int i = 3; i >= 0; i--) plan_byte(hex_char(text_len[i*4 +: 4]));
    plan_byte(bin[7:0]);
    plan_byte(bin[15:8]);
  endfunction

  // Payload from offset 7 up to offset len+4; the type byte sits at offset 10.
  function automatic void plan_body(int len, bit short_type);
    logic [7:0] b;
    for (int off = 7; off <= len + 4; off++) begin
      b = 8'($urandom_range(255));
      if (off == 10) b = short_type ? SHORT_TYPE : byte_except(SHORT_TYPE);
      plan_byte(b);
    end
  endfunction

  function automatic void plan_random_frame();
    int         pick;
    int         len;
    logic [7:0] hdr [7];
    logic [7:0] b;
    pick = $urandom_range(99);
    len  = ($urandom_range(15) == 0) ? $urandom_range(400, 41) : $urandom_range(40, 5);
    if (pick < 35) begin
      // Good normal frame.
      plan_header(16'(len), 16'(len));
      plan_body(len, 1'b0);
      plan_byte(NEWLINE_BYTE);
    end else if (pick < 50) begin
      // Good frame of the short type, no terminator.
      if (len < 6) len = 6;
      plan_header(16'(len), 16'(len));
      plan_body(len, 1'b1);
    end else if (pick < 54) begin
      // Length 5: the type byte doubles as the terminator.
      plan_header(16'd5, 16'd5);
      plan_body(5, 1'b0);
      plan_byte($urandom_range(1) ? SHORT_TYPE : NEWLINE_BYTE);
    end else if (pick < 62) begin
      // Hex and binary lengths disagree in one bit.
      plan_header(16'(len), 16'(len) ^ (16'h1 << $urandom_range(15)));
      plan_noise($urandom_range(6));
    end else if (pick < 68) begin
      // One length digit is not hex; sometimes it is a start byte.
      hdr[0] = START_BYTE;
      for (int i = 0; i < 4; i++) hdr[1 + i] = hex_char(len[(3 - i)*4 +: 4]);
      hdr[5] = len[7:0];
      hdr[6] = len[15:8];
      if ($urandom_range(3) == 0) begin
        b = START_BYTE;
      end else begin
        do b = 8'($urandom_range(255)); while (hex_digit(b) >= 0);
      end
      hdr[1 + $urandom_range(3)] = b;
      for (int i = 0; i < 7; i++) plan_byte(hdr[i]);
      plan_noise($urandom_range(6));
    end else if (pick < 74) begin
      // Consistent but too short.
      len = $urandom_range(4);
      plan_header(16'(len), 16'(len));
      plan_noise($urandom_range(6));
    end else if (pick < 84) begin
      // Terminator replaced by some other byte.
      plan_header(16'(len), 16'(len));
      plan_body(len, 1'b0);
      plan_byte(byte_except(NEWLINE_BYTE));
    end else begin
      plan_noise($urandom_range(8, 1));
    end
  endfunction

  function automatic void build_plan();
    int mark;
    for (int i = 0; i < DIR_ROWS; i++) byte_plan = {byte_plan, directed_rows[i]};
    phase_start[0] = 0;
    while (byte_plan.size() < 340) plan_random_frame();
    phase_start[1] = byte_plan.size();
    while (byte_plan.size() < 660) plan_random_frame();
    phase_start[2] = byte_plan.size();
    mark = byte_plan.size();
    while (byte_plan.size() < mark + 290) plan_random_frame();
  endfunction

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : reset_gen
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The sender walks the byte plan. Idle rates change at the phase marks; the
  // last phase runs without gaps on either side.
  initial begin : sender
    int idx;
    build_plan();
    while (!rst_n) @(posedge clk);
    for (idx = 0; idx < byte_plan.size(); idx++) begin
      if (idx == phase_start[1]) begin
        cur_phase = 1;
        send_idle = 80;
        recv_idle = 14;
      end
      if (idx == phase_start[2]) begin
        cur_phase = 2;
        send_idle = 0;
        recv_idle = 0;
      end
      while ($urandom_range(99) < send_idle) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= byte_plan[idx].data;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_tags.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // At the start of the gap-free phase the receiver stops for a long
  // stretch while bytes keep coming, so both stages fill and in_tready drops.
  initial begin : long_hold
    int n;
    wait (cur_phase == 2);
    @(posedge clk);
    hold_ready <= 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_ready <= 1'b0;
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_ready) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Every accepted input beat moves the tracker and queues one tag.
  always @(posedge clk) begin : predict_on_accept
    tag_t      t;
    plan_row_t row;
    if (rst_n && in_tvalid && in_tready) begin
      row = byte_plan[accept_idx];
      t   = tag_byte(in_tdata);
      if (row.fixed) begin
        t.offset = row.offset;
        t.status = row.status;
        t.last   = (row.status == ST_GOOD_END);
      end
      pending_tags = {pending_tags, t};
      accept_idx++;
    end
  end

  always @(posedge clk) begin : check_results
    tag_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tags.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected result beat: byte %02h offset %0d status %0d last %0b",
                   out_tdata[7:0], out_tdata[24:8], out_tuser, out_tlast);
      end else begin
        want = pending_tags.pop_front();
        if (out_tdata[7:0] !== want.data || out_tdata[24:8] !== want.offset ||
            out_tuser !== want.status || out_tlast !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display({"mismatch: got byte %02h offset %0d status %0d last %0b, ",
                      "want byte %02h offset %0d status %0d last %0b"},
                     out_tdata[7:0], out_tdata[24:8], out_tuser, out_tlast,
                     want.data, want.offset, want.status, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/sfd_pkg.sv
rtl/sfd_tracker.sv
rtl/sonar_frame_delimiter.sv
tb/sv/tb_top.sv
